FILE: src/wmcu_pkg.sv
// Package for the wildcard match coverage union block.
// Holds function codes, configuration indices and field widths used by the lane and top-level modules.
package wmcu_pkg;

    localparam int VAR_W   = 8;
    localparam int MAX_VARS = 8;
    localparam int VALS_W  = 64;
    localparam int COV_W   = 64;
    localparam int SLOT_W  = 8;
    localparam int ENT_W   = 6;

    typedef enum logic [1:0] {
        FUNC_WRITE_ROW = 2'd0,
        FUNC_WRITE_COV = 2'd1,
        FUNC_QUERY     = 2'd2,
        FUNC_NONE      = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        CFG_VARS_IN_USE = 4'd0,
        CFG_ROWS_IN_USE = 4'd1
    } cfg_index_t;

endpackage

FILE: src/wmcu_lane.sv
// One variable lane: compares one stored value against the query value; a wildcard or an unused lane passes.
// Depends on wmcu_pkg for the value width.
module wmcu_lane #(
    parameter int VALUE_BITS = 8
) (
    input  logic [wmcu_pkg::VAR_W-1:0] row_value,
    input  logic                       row_wild,
    input  logic [wmcu_pkg::VAR_W-1:0] query_value,
    input  logic                       query_wild,
    input  logic                       lane_used,
    output logic                       lane_ok
);

    assign lane_ok = !lane_used || row_wild || query_wild
                   || (row_value[VALUE_BITS-1:0] == query_value[VALUE_BITS-1:0]);

endmodule

FILE: src/wildcard_match_coverage_union.sv
// Wildcard match coverage union: a query scans rows 0 .. rows_in_use-1, one row per clock. The
// result strobe is set once the scan has ended and no row read, hit or entry read is still in
// flight; busy falls in the cycle after the strobe.
// The single row-store read port sets the scan rate. Writes are accepted back to back while idle.
// The receiver cannot stall the result.
// Depends on wmcu_pkg and wmcu_lane.
module wildcard_match_coverage_union #(
    parameter int NUM_VARS    = 8,
    parameter int NUM_ROWS    = 256,
    parameter int NUM_ENTRIES = 64,
    parameter int NUM_LOCS    = 64,
    parameter int VALUE_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [7:0]  row_slot,
    input  logic [5:0]  entry_id,
    input  logic [63:0] var_values,
    input  logic [7:0]  wild_mask,
    input  logic [63:0] coverage_bits,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    output logic        result_valid,
    output logic [63:0] covered_set,
    output logic        none_covered
);

    localparam int RA_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int RC_W = $clog2(NUM_ROWS + 1);
    localparam int EA_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int STORE_W = wmcu_pkg::VALS_W + NUM_VARS + wmcu_pkg::ENT_W;
    localparam logic [wmcu_pkg::COV_W-1:0] LOC_MASK =
        (NUM_LOCS >= 64) ? {wmcu_pkg::COV_W{1'b1}}
                         : ((64'd1 << NUM_LOCS) - 64'd1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

    logic [STORE_W-1:0]        row_mem [NUM_ROWS];
    logic [wmcu_pkg::COV_W-1:0] cov_mem [NUM_ENTRIES];

    state_t                    state_reg;
    logic [3:0]                vars_reg;
    logic [8:0]                rows_reg;
    logic [RC_W-1:0]           count_reg;
    logic [RC_W-1:0]           nrows_reg;
    logic [3:0]                nv_reg;
    logic [63:0]               qval_reg;
    logic [7:0]                qwild_reg;
    logic [STORE_W-1:0]        row_rd_reg;
    logic                      row_rd_valid_reg;
    logic                      hit_reg;
    logic [EA_W-1:0]           hit_ent_reg;
    logic [wmcu_pkg::COV_W-1:0] cov_rd_reg;
    logic                      cov_rd_valid_reg;
    logic [wmcu_pkg::COV_W-1:0] acc_reg;
    logic                      result_valid_reg;

    logic [NUM_VARS-1:0] lane_ok;
    logic                row_hit;
    logic [wmcu_pkg::ENT_W-1:0] row_ent;
    logic                accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign row_ent = row_rd_reg[wmcu_pkg::ENT_W-1:0];

    genvar g;
    generate
        for (g = 0; g < NUM_VARS; g++)
        begin : g_lane
            wmcu_lane #(.VALUE_BITS(VALUE_BITS)) u_lane (
                .row_value  (row_rd_reg[STORE_W-64+8*g +: 8]),
                .row_wild   (row_rd_reg[wmcu_pkg::ENT_W + g]),
                .query_value(qval_reg[8*g +: 8]),
                .query_wild (qwild_reg[g]),
                .lane_used  (4'(g) < nv_reg),
                .lane_ok    (lane_ok[g])
            );
        end
    endgenerate

    assign row_hit = row_rd_valid_reg && (&lane_ok)
                   && (32'(row_ent) < NUM_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (accept && func == wmcu_pkg::FUNC_WRITE_ROW && 32'(row_slot) < NUM_ROWS)
        begin
            row_mem[RA_W'(row_slot)] <= {var_values, wild_mask[NUM_VARS-1:0], entry_id};
        end
        if (accept && func == wmcu_pkg::FUNC_WRITE_COV && 32'(entry_id) < NUM_ENTRIES)
        begin
            cov_mem[EA_W'(entry_id)] <= coverage_bits & LOC_MASK;
        end
        row_rd_reg  <= row_mem[RA_W'(count_reg)];
        cov_rd_reg  <= cov_mem[hit_ent_reg];
        hit_ent_reg <= EA_W'(row_ent);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            vars_reg         <= 4'd8;
            rows_reg         <= 9'd0;
            count_reg        <= '0;
            nrows_reg        <= '0;
            nv_reg           <= '0;
            qval_reg         <= '0;
            qwild_reg        <= '0;
            row_rd_valid_reg <= 1'b0;
            hit_reg          <= 1'b0;
            cov_rd_valid_reg <= 1'b0;
            acc_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_we && cfg_index == wmcu_pkg::CFG_VARS_IN_USE)
            begin
                vars_reg <= cfg_data[3:0];
            end
            if (cfg_we && cfg_index == wmcu_pkg::CFG_ROWS_IN_USE)
            begin
                rows_reg <= cfg_data;
            end
            hit_reg          <= row_hit;
            cov_rd_valid_reg <= hit_reg;
            if (cov_rd_valid_reg)
            begin
                acc_reg <= acc_reg | cov_rd_reg;
            end
            case (state_reg)
                S_IDLE:
                begin
                    row_rd_valid_reg <= 1'b0;
                    if (accept && func == wmcu_pkg::FUNC_QUERY)
                    begin
                        count_reg <= '0;
                        nrows_reg <= (32'(rows_reg) > NUM_ROWS) ? RC_W'(NUM_ROWS)
                                                                 : RC_W'(rows_reg);
                        nv_reg    <= (32'(vars_reg) > NUM_VARS) ? 4'(NUM_VARS) : vars_reg;
                        qval_reg  <= var_values;
                        qwild_reg <= wild_mask;
                        acc_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (count_reg < nrows_reg)
                    begin
                        row_rd_valid_reg <= 1'b1;
                        count_reg        <= count_reg + RC_W'(1);
                    end
                    else
                    begin
                        row_rd_valid_reg <= 1'b0;
                        state_reg        <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    row_rd_valid_reg <= 1'b0;
                    if (!row_rd_valid_reg && !hit_reg && !cov_rd_valid_reg)
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign covered_set  = acc_reg & LOC_MASK;
    assign none_covered = ((acc_reg & LOC_MASK) == '0);

`ifndef SYNTHESIS
    a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_DRAIN))
        else $error("result strobe outside drain");
    a_no_hit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !cov_rd_valid_reg)
        else $error("coverage read while idle");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> count_reg <= nrows_reg)
        else $error("row counter overran");
`endif

endmodule
